@@ rtl/tqlb_pkg.sv @@
// ----------------------------------------------------------------------------
// tqlb_pkg
// Types, constants, binning and reward functions for the Q-learning balance controller.
// ----------------------------------------------------------------------------
package tqlb_pkg;

    localparam int NUM_STATES  = 315;
    localparam int NUM_ACTIONS = 3;
    localparam int TABLE_DEPTH = 945;
    localparam int ADDR_W      = 10;
    localparam int STATE_W     = 9;
    localparam int REW_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRAINING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_K    = 2'd3;

    // Action codes
    localparam logic [1:0] ACT_STOP    = 2'd0;
    localparam logic [1:0] ACT_REVERSE = 2'd1;
    localparam logic [1:0] ACT_FORWARD = 2'd2;

    typedef enum logic [9:0] {
        S_CLR  = 10'b00_0000_0001,
        S_IDLE = 10'b00_0000_0010,
        S_RD   = 10'b00_0000_0100,
        S_MAX  = 10'b00_0000_1000,
        S_MUL  = 10'b00_0001_0000,
        S_DIFF = 10'b00_0010_0000,
        S_NUM  = 10'b00_0100_0000,
        S_DIV  = 10'b00_1000_0000,
        S_WR   = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    function automatic logic [2:0] bin_angle(input logic [12:0] a);
        logic [2:0] b;
        if (a > 13'd2800)      b = 3'd1;
        else if (a > 13'd2600) b = 3'd2;
        else if (a < 13'd2300) b = 3'd0;
        else if (a < 13'd2500) b = 3'd3;
        else if (a < 13'd2530) b = 3'd4;
        else if (a > 13'd2570) b = 3'd5;
        else                   b = 3'd6;
        return b;
    endfunction

    function automatic logic [2:0] bin_rate(input logic signed [13:0] d);
        logic [2:0] b;
        if (d > 14'sd15)       b = 3'd0;
        else if (d > 14'sd5)   b = 3'd2;
        else if (d < -14'sd15) b = 3'd1;
        else if (d < -14'sd5)  b = 3'd3;
        else                   b = 3'd4;
        return b;
    endfunction

    function automatic logic signed [REW_W-1:0] reward_of(input logic [2:0] ab,
                                                        input logic [2:0] rb,
                                                        input logic [1:0] pb,
                                                        input logic [1:0] sb);
        logic signed [REW_W-1:0] r;
        if (ab == 3'd6)                    r = 7'sd20;
        else if (ab == 3'd4 || ab == 3'd5) r = 7'sd10;
        else if (ab == 3'd2 || ab == 3'd3) r = -7'sd5;
        else                               r = -7'sd20;
        if (rb == 3'd4)                    r = r + 7'sd20;
        else if (rb == 3'd2 || rb == 3'd3) r = r + 7'sd5;
        else                               r = r - 7'sd20;
        if (pb == 2'd2) r = r + 7'sd10;
        if (sb == 2'd2) r = r + 7'sd10;
        return r;
    endfunction

endpackage

@@ rtl/tabular_q_learning_balance_controller_unit.sv @@
// ----------------------------------------------------------------------------
// tabular_q_learning_balance_controller_unit
// Bins pendulum samples, updates the Q/visit tables and picks a motor action.
// ----------------------------------------------------------------------------
// Timing: an item that only stores its sample passes through S_DONE, and o_valid
// rises when the output register loads. An updating item first runs the table
// reads, four arithmetic steps, divider load, bit-serial learning-rate divide and
// write-back, then the output register. One item at a time: the next transfer
// waits until the result is loaded, longer while an earlier result waits. After
// reset both tables are cleared over all 945 entries with no item taken; config writes taken throughout.
module tabular_q_learning_balance_controller_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tqlb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tqlb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [12:0]                         i_angle_mv,
    input  logic [11:0]                         i_position_mm,
    input  logic                                i_in_limits,
    input  logic [15:0]                         i_explore_draw,
    input  logic [1:0]                          i_random_action,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_acted,
    output logic [1:0]                          o_action,
    output logic                                o_motor_a,
    output logic                                o_motor_b,
    output logic signed [31:0]                  o_updated_q,
    output logic [15:0]                         o_visit_count
);

    import tqlb_pkg::*;

    localparam int CW  = COUNT_WIDTH;
    localparam int VW  = CW + 1;
    localparam int DW  = 44;
    localparam logic [CW-1:0] CMAX = '1;

    // Configuration
    logic        r_training;
    logic [15:0] r_thr;
    logic [14:0] r_disc;
    logic [7:0]  r_k;

    // Episode state
    t_state              r_state;
    logic [12:0]         r_last_ang;
    logic [11:0]         r_last_pos;
    logic                r_primed;
    logic                r_have_prev;
    logic [STATE_W-1:0]  r_prev_st;
    logic [1:0]          r_prev_act;
    logic signed [REW_W-1:0] r_prev_rew;

    // Working registers
    logic [ADDR_W-1:0]   r_clr;
    logic [2:0]          r_cnt;
    logic [STATE_W-1:0]  r_st;
    logic signed [REW_W-1:0] r_rew;
    logic [15:0]         r_draw;
    logic [1:0]          r_rnd;
    logic signed [31:0]  r_q [4];
    logic [CW-1:0]       r_v [4];
    logic [CW-1:0]       r_n;
    logic signed [31:0]  r_m;
    logic signed [47:0]  r_prod;
    logic signed [34:0]  r_d;
    logic                r_neg;
    logic [DW-1:0]       r_dvd;
    logic [VW-1:0]       r_den;
    logic                r_div_go;

    // Result staging and output register
    logic                r_s_acted;
    logic [1:0]          r_s_act;
    logic signed [31:0]  r_s_q;
    logic [CW-1:0]       r_s_n;
    logic                r_ovalid;

    // Sample binning
    logic signed [13:0]  n_dang;
    logic signed [12:0]  n_dpos;
    logic [2:0]          n_ab, n_rb;
    logic [1:0]          n_pb, n_sb;
    logic [STATE_W-1:0]  n_st;
    logic signed [REW_W-1:0] n_rew;

    always_comb begin
        n_dang = $signed({1'b0, r_last_ang}) - $signed({1'b0, i_angle_mv});
        n_dpos = $signed({1'b0, r_last_pos}) - $signed({1'b0, i_position_mm});
        n_ab   = bin_angle(i_angle_mv);
        n_rb   = bin_rate(n_dang);
        if (i_position_mm > 12'd700)      n_pb = 2'd0;
        else if (i_position_mm < 12'd300) n_pb = 2'd1;
        else                              n_pb = 2'd2;
        if (n_dpos < 13'sd300 && n_dpos > -13'sd300) n_sb = 2'd2;
        else if (n_dpos > 13'sd0)                    n_sb = 2'd1;
        else                                         n_sb = 2'd0;
        n_st  = STATE_W'((({6'd0, n_ab} * 9'd5 + {6'd0, n_rb}) * 9'd3 + {7'd0, n_pb})
                         * 9'd3 + {7'd0, n_sb});
        n_rew = reward_of(n_ab, n_rb, n_pb, n_sb);
    end

    // Table addressing
    logic [ADDR_W-1:0] n_idx;
    logic [ADDR_W-1:0] n_base;
    logic [ADDR_W-1:0] n_ent [NUM_ACTIONS];
    logic [ADDR_W-1:0] n_addr;
    logic              n_we;
    logic signed [31:0] n_wq;
    logic [CW-1:0]     n_wv;

    always_comb begin
        n_idx  = ADDR_W'({1'b0, r_prev_st} * 10'd3 + {8'd0, r_prev_act});
        n_base = ADDR_W'({1'b0, r_st} * 10'd3);
        for (int a = 0; a < NUM_ACTIONS; a++) begin
            n_ent[a] = n_base + ADDR_W'(a);
        end
    end

    // Bit-serial learning-rate divider
    logic [DW-1:0] w_quo;
    logic          w_done;

    tqlb_div #(.DW(DW), .VW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_dvd),
        .i_divisor  (r_den),
        .o_quotient (w_quo),
        .o_done     (w_done)
    );

    // New Q with saturation
    logic signed [44:0] n_step;
    logic signed [44:0] n_sum;
    logic signed [31:0] n_nq;

    always_comb begin
        n_step = r_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
        n_sum  = $signed({{13{r_q[0][31]}}, r_q[0]}) + n_step;
        if (n_sum > 45'sd2147483647)       n_nq = 32'sh7FFF_FFFF;
        else if (n_sum < -45'sd2147483648) n_nq = 32'sh8000_0000;
        else                               n_nq = n_sum[31:0];
    end

    // Action choice over the new state
    logic signed [31:0] n_qs [NUM_ACTIONS];
    logic signed [31:0] n_bq;
    logic [1:0]         n_best;
    logic [1:0]         n_act;

    always_comb begin
        for (int a = 0; a < NUM_ACTIONS; a++) begin
            n_qs[a] = (n_ent[a] == n_idx) ? n_nq : r_q[a + 1];
        end
        n_best = ACT_STOP;
        n_bq   = n_qs[0];
        for (int a = 1; a < NUM_ACTIONS; a++) begin
            if (n_qs[a] > n_bq) begin
                n_bq   = n_qs[a];
                n_best = 2'(a);
            end
        end
        if (r_training && r_draw < r_thr) begin
            n_act = (r_rnd == 2'd3) ? ACT_FORWARD : r_rnd;
        end else begin
            n_act = n_best;
        end
    end

    // Largest Q among visited actions
    logic signed [31:0] n_m;
    logic               n_found;
    logic               n_vis;

    always_comb begin
        n_m     = '0;
        n_found = 1'b0;
        n_vis   = 1'b0;
        for (int a = 0; a < NUM_ACTIONS; a++) begin
            n_vis = (n_ent[a] == n_idx) || (r_v[a + 1] != '0);
            if (n_vis && (!n_found || r_q[a + 1] > n_m)) begin
                n_m     = r_q[a + 1];
                n_found = 1'b1;
            end
        end
    end

    // Memory port control
    always_comb begin
        n_we   = 1'b0;
        n_wq   = '0;
        n_wv   = '0;
        n_addr = n_idx;
        unique case (r_state)
            S_CLR: begin
                n_we   = 1'b1;
                n_addr = r_clr;
            end
            S_RD: begin
                priority if (r_cnt == 3'd0) n_addr = n_idx;
                else if (r_cnt == 3'd1)     n_addr = n_ent[0];
                else if (r_cnt == 3'd2)     n_addr = n_ent[1];
                else                        n_addr = n_ent[2];
            end
            S_WR: begin
                if (w_done) begin
                    n_we = 1'b1;
                    n_wq = n_nq;
                    n_wv = r_n;
                end
            end
            default: n_addr = n_idx;
        endcase
    end

    logic signed [31:0] w_qrd;
    logic [CW-1:0]      w_vrd;

    tqlb_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_qram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_addr  (n_addr),
        .i_wdata (n_wq),
        .o_rdata (w_qrd)
    );

    tqlb_ram #(.WIDTH(CW), .DEPTH(TABLE_DEPTH)) u_vram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_addr  (n_addr),
        .i_wdata (n_wv),
        .o_rdata (w_vrd)
    );

    assign o_ready = (r_state == S_IDLE);

    // Intermediate arithmetic values
    logic signed [47:0] n_gsum;
    logic signed [32:0] n_g;
    logic signed [43:0] n_num;
    logic [43:0]        n_mag;

    always_comb begin
        n_gsum = r_prod + 48'sd16384;
        n_g    = 33'(n_gsum >>> 15);
        n_num  = r_d * $signed({1'b0, r_k});
        n_mag  = n_num[43] ? 44'(-n_num) : 44'(n_num);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_training <= 1'b1;
            r_thr      <= 16'd32768;
            r_disc     <= 15'd31130;
            r_k        <= 8'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRAINING:  r_training <= i_cfg_data[0];
                CFG_THRESHOLD: r_thr      <= i_cfg_data;
                CFG_DISCOUNT:  r_disc     <= i_cfg_data[14:0];
                CFG_RATE_K:    r_k        <= i_cfg_data[7:0];
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_last_ang  <= '0;
            r_last_pos  <= '0;
            r_primed    <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev_st   <= '0;
            r_prev_act  <= ACT_STOP;
            r_prev_rew  <= '0;
            r_div_go    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            // Load a new result, else drop the one just transferred
            if (r_state == S_DONE && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(TABLE_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_last_ang <= i_angle_mv;
                        r_last_pos <= i_position_mm;
                        r_primed   <= 1'b1;
                        r_s_acted  <= 1'b0;
                        r_s_act    <= ACT_STOP;
                        r_s_q      <= '0;
                        r_s_n      <= '0;
                        r_st       <= n_st;
                        r_rew      <= n_rew;
                        r_draw     <= i_explore_draw;
                        r_rnd      <= i_random_action;
                        r_cnt      <= '0;
                        priority if (!r_primed) begin
                            r_state <= S_DONE;
                        end else if (!i_in_limits) begin
                            r_primed    <= 1'b0;
                            r_have_prev <= 1'b0;
                            r_prev_act  <= ACT_STOP;
                            r_prev_rew  <= '0;
                            r_state     <= S_DONE;
                        end else if (!r_have_prev) begin
                            r_have_prev <= 1'b1;
                            r_prev_st   <= n_st;
                            r_state     <= S_DONE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    // Capture the entry addressed in the previous S_RD step
                    if (r_cnt != 3'd0) begin
                        r_q[r_cnt[1:0] - 2'd1] <= w_qrd;
                        r_v[r_cnt[1:0] - 2'd1] <= w_vrd;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 3'd4) begin
                        r_state <= S_MAX;
                    end
                end
                S_MAX: begin
                    r_n     <= (r_v[0] == CMAX) ? r_v[0] : r_v[0] + 1'b1;
                    r_m     <= n_m;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_m * $signed({1'b0, r_disc});
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_d <= $signed({{12{r_prev_rew[REW_W-1]}}, r_prev_rew, 16'd0})
                           + 35'(n_g) - 35'(r_q[0]);
                    r_den   <= VW'(r_k) + VW'(r_n);
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_neg    <= n_num[43];
                    r_dvd    <= n_mag + DW'(r_den >> 1);
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    // Write back and choose the action once the quotient lands
                    if (w_done) begin
                        r_s_acted  <= 1'b1;
                        r_s_act    <= n_act;
                        r_s_q      <= n_nq;
                        r_s_n      <= r_n;
                        r_prev_act <= n_act;
                        r_prev_rew <= r_rew;
                        r_prev_st  <= r_st;
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        o_acted       <= r_s_acted;
                        o_action      <= r_s_act;
                        o_motor_a     <= (r_s_act == ACT_FORWARD);
                        o_motor_b     <= (r_s_act == ACT_REVERSE);
                        o_updated_q   <= r_s_q;
                        o_visit_count <= 16'(r_s_n);
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;

endmodule

@@ rtl/tqlb_ram.sv @@
// ----------------------------------------------------------------------------
// tqlb_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tqlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 945
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write when enabled; the read always returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

@@ rtl/tqlb_div.sv @@
// ----------------------------------------------------------------------------
// tqlb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tqlb_div #(
    parameter int DW = 44,
    parameter int VW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient,
    output logic          o_done
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VW:0]      n_sh;
    logic [VW:0]      n_diff;

    // Shift in next dividend bit and trial subtract
    always_comb begin
        n_sh   = {r_rem, r_quo[DW-1]};
        n_diff = n_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (n_sh >= {1'b0, r_div}) begin
                    r_rem <= n_diff[VW-1:0];
                    r_quo <= {r_quo[DW-2:0], 1'b1};
                end else begin
                    r_rem <= n_sh[VW-1:0];
                    r_quo <= {r_quo[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

@@ test/tabular_q_learning_balance_controller_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tabular_q_learning_balance_controller_unit_test
// Drives sensor samples through the Q-learning balance controller and checks
// every result against a cycle-free predictor of binning, reward, Q update
// and epsilon-greedy action selection, across several register settings.
// ----------------------------------------------------------------------------
module tabular_q_learning_balance_controller_unit_test;
    import tqlb_pkg::*;

    localparam int COUNT_MAX = 65535;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [12:0] angle;
        logic [11:0] pos;
        logic        limits;
        logic [15:0] draw;
        logic [1:0]  rnd;
    } t_sample;

    typedef struct packed {
        logic        acted;
        logic [1:0]  action;
        logic        motor_a;
        logic        motor_b;
        logic [31:0] q;
        logic [15:0] visits;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [12:0] i_angle_mv = '0;
    logic [11:0] i_position_mm = '0;
    logic        i_in_limits = 1'b0;
    logic [15:0] i_explore_draw = '0;
    logic [1:0]  i_random_action = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_acted;
    logic [1:0]  o_action;
    logic        o_motor_a;
    logic        o_motor_b;
    logic signed [31:0] o_updated_q;
    logic [15:0] o_visit_count;

    tabular_q_learning_balance_controller_unit dut (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state
    logic signed [31:0] q_tab [TABLE_DEPTH];
    int unsigned        visit_tab [TABLE_DEPTH];
    int  p_last_angle, p_last_pos, p_prev_state, p_prev_action, p_prev_reward;
    bit  p_primed, p_have_state;
    bit  c_training;
    int  c_threshold, c_discount, c_rate_k;

    t_sample  pending_samples [$];
    t_outcome expected_outcomes [$];
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_off = 1'b0;
    bit  stim_done = 1'b0;
    bit  in_taken = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    // Work out the result of one sample and advance the predictor
    function automatic t_outcome predict_outcome(input t_sample s);
        t_outcome o;
        int  da, dp, ab, rb, pb, sb, st, idx, rew, a, best;
        longint m, g, d, step, nq;
        bit found;
        o = '0;
        da = p_last_angle - int'(s.angle);
        dp = p_last_pos - int'(s.pos);
        p_last_angle = s.angle;
        p_last_pos = s.pos;
        if (!p_primed) begin
            p_primed = 1'b1;
            return o;
        end
        if (!s.limits) begin
            p_primed = 1'b0;
            p_have_state = 1'b0;
            p_prev_action = 0;
            p_prev_reward = 0;
            return o;
        end
        if (s.angle > 2800)      ab = 1;
        else if (s.angle > 2600) ab = 2;
        else if (s.angle < 2300) ab = 0;
        else if (s.angle < 2500) ab = 3;
        else if (s.angle < 2530) ab = 4;
        else if (s.angle > 2570) ab = 5;
        else                     ab = 6;
        if (da > 15)       rb = 0;
        else if (da > 5)   rb = 2;
        else if (da < -15) rb = 1;
        else if (da < -5)  rb = 3;
        else               rb = 4;
        pb = (s.pos > 700) ? 0 : ((s.pos < 300) ? 1 : 2);
        if (dp < 300 && dp > -300) sb = 2;
        else if (dp > 0)           sb = 1;
        else                       sb = 0;
        st = ((ab * 5 + rb) * 3 + pb) * 3 + sb;
        if (ab == 6)                rew = 20;
        else if (ab == 4 || ab == 5) rew = 10;
        else if (ab == 2 || ab == 3) rew = -5;
        else                         rew = -20;
        if (rb == 4)                 rew += 20;
        else if (rb == 2 || rb == 3) rew += 5;
        else                         rew -= 20;
        if (pb == 2) rew += 10;
        if (sb == 2) rew += 10;
        if (!p_have_state) begin
            p_have_state = 1'b1;
            p_prev_state = st;
            return o;
        end
        idx = p_prev_state * 3 + p_prev_action;
        if (visit_tab[idx] < COUNT_MAX) visit_tab[idx]++;
        m = 0;
        found = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (visit_tab[st * 3 + j] != 0 && (!found || q_tab[st * 3 + j] > m)) begin
                m = q_tab[st * 3 + j];
                found = 1'b1;
            end
        end
        g = (m * c_discount + 16384) >>> 15;
        d = longint'(p_prev_reward) * 65536 + g - q_tab[idx];
        step = round_div(d * c_rate_k, c_rate_k + visit_tab[idx]);
        nq = q_tab[idx] + step;
        if (nq > 64'sd2147483647) nq = 64'sd2147483647;
        if (nq < -64'sd2147483648) nq = -64'sd2147483648;
        q_tab[idx] = 32'(nq);
        if (c_training && s.draw < c_threshold) begin
            a = (s.rnd == 2'd3) ? 2 : s.rnd;
        end else begin
            best = 0;
            for (int j = 1; j < 3; j++)
                if (q_tab[st * 3 + j] > q_tab[st * 3 + best]) best = j;
            a = best;
        end
        o.acted = 1'b1;
        o.action = 2'(a);
        o.motor_a = (a == ACT_FORWARD);
        o.motor_b = (a == ACT_REVERSE);
        o.q = q_tab[idx];
        o.visits = 16'(visit_tab[idx]);
        p_prev_action = a;
        p_prev_reward = rew;
        p_prev_state = st;
        return o;
    endfunction

    // Driver: offer queued samples, hold each until its transfer
    always @(negedge i_clk) begin
        if (i_valid && !in_taken) begin
            // hold the offered sample until transfer
        end else if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
            i_valid <= 1'b1;
            {i_angle_mv, i_position_mm, i_in_limits, i_explore_draw, i_random_action}
                <= pending_samples[0];
        end else begin
            i_valid <= 1'b0;
        end
        in_taken = 1'b0;
        i_ready <= !hold_off && (calm || $urandom_range(99) >= 27);
    end

    // Predict each sample at its transfer and retire it from the queue
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_outcomes.push_back(predict_outcome(
                {i_angle_mv, i_position_mm, i_in_limits, i_explore_draw, i_random_action}));
            void'(pending_samples.pop_front());
            in_taken = 1'b1;
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("unexpected result", o_acted, 0);
            end else begin
                w = expected_outcomes.pop_front();
                if (o_acted !== w.acted) report_mismatch("acted", o_acted, w.acted);
                if (o_action !== w.action) report_mismatch("action", o_action, w.action);
                if (o_motor_a !== w.motor_a) report_mismatch("motor_a", o_motor_a, w.motor_a);
                if (o_motor_b !== w.motor_b) report_mismatch("motor_b", o_motor_b, w.motor_b);
                if (o_updated_q !== w.q)
                    report_mismatch("updated_q", o_updated_q, $signed(w.q));
                if (o_visit_count !== w.visits)
                    report_mismatch("visit_count", o_visit_count, w.visits);
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || stim_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TRAINING:  c_training = value[0];
            CFG_THRESHOLD: c_threshold = value[15:0];
            CFG_DISCOUNT:  c_discount = value[14:0];
            default:       c_rate_k = value[7:0];
        endcase
    endtask

    task automatic drain;
        wait (pending_samples.size() == 0 && !i_valid);
        wait (expected_outcomes.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic add_sample(input int a, input int p, input bit lim,
                              input int draw, input int rnd);
        t_sample s;
        s.angle = 13'(a);
        s.pos = 12'(p);
        s.limits = lim;
        s.draw = 16'(draw);
        s.rnd = 2'(rnd);
        pending_samples.push_back(s);
    endtask

    // A mostly well-formed episode around the balance point
    task automatic add_episode(input int len);
        int a, p;
        a = $urandom_range(2200, 2900);
        p = $urandom_range(0, 1000);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
                a = $urandom_range(0, 8191);
                p = $urandom_range(0, 4095);
            end else begin
                a = a + $urandom_range(0, 60) - 30;
                p = p + $urandom_range(0, 800) - 400;
                if (a < 0) a = 0;
                if (a > 8191) a = 8191;
                if (p < 0) p = 0;
                if (p > 4095) p = 4095;
            end
            add_sample(a, p, (i == len - 1) || $urandom_range(49) == 0 ? 1'b0 : 1'b1,
                       $urandom_range(0, 65535), $urandom_range(0, 3));
        end
    endtask

    initial begin
        int sent;
        foreach (q_tab[i]) begin
            q_tab[i] = 0;
            visit_tab[i] = 0;
        end
        p_last_angle = 0; p_last_pos = 0; p_prev_state = 0;
        p_prev_action = 0; p_prev_reward = 0;
        p_primed = 1'b0; p_have_state = 1'b0;
        c_training = 1'b1; c_threshold = 32768; c_discount = 31130; c_rate_k = 10;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every band, every action, episode end
        write_reg(CFG_THRESHOLD, 65535);
        add_sample(0, 0, 1'b1, 0, 0);
        add_sample(2550, 500, 1'b1, 0, 0);
        add_sample(2550, 500, 1'b1, 0, 1);
        add_sample(2560, 490, 1'b1, 0, 2);
        add_sample(2540, 510, 1'b1, 0, 3);
        add_sample(2520, 800, 1'b1, 0, 0);
        add_sample(2580, 100, 1'b1, 65534, 1);
        add_sample(2480, 700, 1'b1, 0, 2);
        add_sample(2700, 300, 1'b1, 0, 3);
        add_sample(2900, 4095, 1'b1, 0, 1);
        add_sample(2200, 0, 1'b1, 0, 2);
        add_sample(8191, 4095, 1'b1, 65535, 3);
        add_sample(6144, 2000, 1'b1, 0, 0);
        add_sample(2550, 500, 1'b0, 0, 0);
        add_sample(2550, 500, 1'b1, 0, 0);
        drain();

        // Greedy only, no discount, slowest learning
        write_reg(CFG_TRAINING, 0);
        write_reg(CFG_DISCOUNT, 0);
        write_reg(CFG_RATE_K, 1);
        add_sample(2550, 500, 1'b1, 0, 0);
        add_sample(2550, 500, 1'b1, 0, 0);
        for (int i = 0; i < 6; i++) add_sample(2550, 500, 1'b1, 0, 0);
        drain();

        // Random part over several settings
        sent = 0;
        calm = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_TRAINING, 1); write_reg(CFG_THRESHOLD, 32768);
                    write_reg(CFG_DISCOUNT, 32767); write_reg(CFG_RATE_K, 255);
                end
                1: begin
                    write_reg(CFG_THRESHOLD, 0); write_reg(CFG_DISCOUNT, 31130);
                    write_reg(CFG_RATE_K, 10);
                end
                2: begin
                    write_reg(CFG_THRESHOLD, 65535); write_reg(CFG_RATE_K, 128);
                end
                default: begin
                    write_reg(CFG_TRAINING, 0); write_reg(CFG_DISCOUNT, 16000);
                    write_reg(CFG_RATE_K, 3);
                end
            endcase
            for (int k = 0; k < 200; ) begin
                int len;
                len = $urandom_range(3, 40);
                add_episode(len);
                k += len;
                if (phase == 1 && k > 40 && k <= 40 + len) begin
                    hold_off = 1'b1;
                    repeat (400) @(negedge i_clk);
                    hold_off = 1'b0;
                end
                wait (pending_samples.size() < 10);
                if (k > 100) calm = 1'b0;
            end
            drain();
            calm = (phase == 1);
        end

        stim_done = 1'b1;
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
